// ===== design/stdi_pkg.sv =====
package stdi_pkg;

  localparam int CHAR_W = 8;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOROOM   = 2'd3
  } stdi_status_t;

  // request from the string collector to the table engine
  typedef struct packed {
    logic done;
    logic empty;
    logic overflow;
    logic tails;
  } stdi_req_t;

endpackage

// ===== design/stdi_ram.sv =====
module stdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stdi_collect.sv =====
module stdi_collect import stdi_pkg::*; #(
  parameter int MAX_LEN = 64,
  localparam int LW  = $clog2(MAX_LEN + 1),
  localparam int BAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  input  logic              share_suffix,
  output logic              buf_we,
  output logic [BAW-1:0]    buf_waddr,
  output logic [CHAR_W-1:0] buf_wdata,
  output stdi_req_t         req,
  output logic [LW-1:0]     req_len
);

  logic [LW-1:0] len_r, len_nxt, len_u;
  logic          ended_r, ended_nxt, ended_u;
  logic          ovf_r, ovf_nxt, ovf_u;
  logic          room;

  assign room = (len_r < LW'(MAX_LEN));

  always_comb begin
    len_u   = len_r;
    ended_u = ended_r;
    ovf_u   = ovf_r;
    buf_we  = 1'b0;
    if (acc && !ended_r) begin
      if (char_code == '0) begin
        ended_u = 1'b1;
      end else if (room) begin
        buf_we = 1'b1;
        len_u  = len_r + LW'(1);
      end else begin
        ovf_u = 1'b1;
      end
    end
    // the last byte hands the string over and starts a fresh one
    if (acc && last_char) begin
      len_nxt   = '0;
      ended_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end else begin
      len_nxt   = len_u;
      ended_nxt = ended_u;
      ovf_nxt   = ovf_u;
    end
  end

  assign buf_waddr    = len_r[BAW-1:0];
  assign buf_wdata    = char_code;
  assign req.done     = acc && last_char;
  assign req.empty    = (len_u == '0);
  assign req.overflow = ovf_u;
  assign req.tails    = share_suffix;
  assign req_len      = len_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ended_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      ended_r <= ended_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== design/stdi_engine.sv =====
module stdi_engine import stdi_pkg::*; #(
  parameter int TABLE_BYTES = 4096,
  parameter int MAX_LEN     = 64,
  localparam int AW  = $clog2(TABLE_BYTES),
  localparam int FW  = $clog2(TABLE_BYTES + 1),
  localparam int LW  = $clog2(MAX_LEN + 1),
  localparam int BAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stdi_req_t          req,
  input  logic [LW-1:0]      req_len,
  output logic               busy,
  output logic               st_we,
  output logic [AW-1:0]      st_waddr,
  output logic [CHAR_W-1:0]  st_wdata,
  output logic [AW-1:0]      st_raddr,
  input  logic [CHAR_W-1:0]  st_rdata,
  output logic [BAW-1:0]     buf_raddr,
  input  logic [CHAR_W-1:0]  buf_rdata,
  output logic               res_valid,
  input  logic               res_take,
  output stdi_status_t       res_status,
  output logic [AW-1:0]      res_offset
);

  localparam int CW = ((FW > LW) ? FW : LW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_CMP, S_ROOM, S_COPY, S_TERM, S_RESULT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [CW-1:0] cs_r, cs_nxt;
  logic [LW-1:0] ci_r, ci_nxt;
  logic          v_r, v_nxt;
  logic [LW-1:0] slen_r, slen_nxt;
  logic          tails_r, tails_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  stdi_status_t  status_r, status_nxt;
  logic [AW-1:0] off_r, off_nxt;

  logic [CW-1:0] end_w, elen, slen_c, fill_c, next_w, cmp_a, wr_a;

  assign slen_c = CW'(slen_r);
  assign fill_c = CW'(fill_r);
  assign end_w  = a_r - CW'(1);
  assign elen   = end_w - pos_r;
  assign next_w = end_r + CW'(1);
  assign cmp_a  = cs_r + CW'(ci_r);
  assign wr_a   = fill_c + CW'(ci_r) - CW'(1);

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    cs_nxt     = cs_r;
    ci_nxt     = ci_r;
    v_nxt      = v_r;
    slen_nxt   = slen_r;
    tails_nxt  = tails_r;
    fill_nxt   = fill_r;
    status_nxt = status_r;
    off_nxt    = off_r;
    st_we      = 1'b0;
    st_waddr   = wr_a[AW-1:0];
    st_wdata   = buf_rdata;
    st_raddr   = a_r[AW-1:0];
    buf_raddr  = ci_r[BAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req.done) begin
          slen_nxt  = req_len;
          tails_nxt = req.tails;
          pos_nxt   = '0;
          a_nxt     = '0;
          v_nxt     = 1'b0;
          off_nxt   = '0;
          if (req.empty) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_RESULT;
          end else if (req.overflow) begin
            status_nxt = ST_NOROOM;
            state_nxt  = S_RESULT;
          end else if (fill_r == '0) begin
            state_nxt = S_ROOM;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        // stream the store, data arrives in the cycle after its address
        a_nxt = a_r + CW'(1);
        v_nxt = 1'b1;
        if (v_r && st_rdata == '0) begin
          end_nxt = end_w;
          if (elen == slen_c) begin
            cs_nxt    = pos_r;
            ci_nxt    = '0;
            v_nxt     = 1'b0;
            state_nxt = S_CMP;
          end else if (tails_r && elen > slen_c) begin
            cs_nxt    = end_w - slen_c;
            ci_nxt    = '0;
            v_nxt     = 1'b0;
            state_nxt = S_CMP;
          end else begin
            pos_nxt = a_r;
            if (a_r >= fill_c) begin
              state_nxt = S_ROOM;
            end
          end
        end
      end
      S_CMP: begin
        st_raddr = cmp_a[AW-1:0];
        ci_nxt   = ci_r + LW'(1);
        v_nxt    = 1'b1;
        if (v_r) begin
          if (st_rdata != buf_rdata) begin
            pos_nxt = next_w;
            a_nxt   = next_w;
            v_nxt   = 1'b0;
            state_nxt = (next_w >= fill_c) ? S_ROOM : S_FIND;
          end else if (ci_r == slen_r) begin
            status_nxt = ST_PRESENT;
            off_nxt    = cs_r[AW-1:0];
            state_nxt  = S_RESULT;
          end
        end
      end
      S_ROOM: begin
        ci_nxt = '0;
        v_nxt  = 1'b0;
        if (slen_c + CW'(1) > CW'(TABLE_BYTES) - fill_c) begin
          status_nxt = ST_NOROOM;
          off_nxt    = '0;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        ci_nxt = ci_r + LW'(1);
        v_nxt  = 1'b1;
        if (v_r) begin
          st_we = 1'b1;
          if (ci_r == slen_r) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        st_we      = 1'b1;
        st_waddr   = AW'(fill_c + slen_c);
        st_wdata   = '0;
        status_nxt = ST_INSERTED;
        off_nxt    = fill_r[AW-1:0];
        fill_nxt   = FW'(fill_c + slen_c + CW'(1));
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = (state_r == S_RESULT);
  assign res_status = status_r;
  assign res_offset = off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      v_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      v_r      <= v_nxt;
      a_r      <= a_nxt;
      pos_r    <= pos_nxt;
      end_r    <= end_nxt;
      cs_r     <= cs_nxt;
      ci_r     <= ci_nxt;
      slen_r   <= slen_nxt;
      tails_r  <= tails_nxt;
      status_r <= status_nxt;
      off_r    <= off_nxt;
    end
  end

endmodule

// ===== design/string_table_dedup_insert.sv =====
// string table with deduplication and optional suffix sharing
//
// input channel: one byte per item (in_char_code), in_last_char on the final
// byte, in_share_suffix sampled with the final byte. a zero byte ends the
// string early, later bytes up to the final one are ignored.
// result channel: one item (out_status, out_offset) per string, none for
// other bytes.
// throughput: bytes before the final one are taken every cycle while the
// engine is idle. the final byte starts a byte-serial pass over the
// stored table through the single read port of the table memory, which
// compares each candidate entry and appends the string when none matches
// and there is room, then hands the result to the output register.
// in_stall is high until the result leaves the engine. empty or too-long
// strings are answered without a pass over the table.
// reset: the table fill level and the string collector clear at once, no
// clearing pass is needed, table bytes above the fill level are never used.
// a result waiting under out_stall holds; bytes of the next string are still
// taken, the answer to its final byte waits in the engine, with in_stall
// high, until the output register frees up.
module string_table_dedup_insert import stdi_pkg::*; #(
  parameter int TABLE_BYTES = 4096,
  parameter int MAX_LEN     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              in_last_char,
  input  logic              in_share_suffix,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [OFF_W-1:0]  out_offset
);

  localparam int AW  = $clog2(TABLE_BYTES);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int BAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic              in_acc;
  logic              busy;

  // string buffer ports
  logic              buf_we;
  logic [BAW-1:0]    buf_waddr;
  logic [CHAR_W-1:0] buf_wdata;
  logic [BAW-1:0]    buf_raddr;
  logic [CHAR_W-1:0] buf_rdata;

  // table store ports
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [CHAR_W-1:0] st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [CHAR_W-1:0] st_rdata;

  stdi_req_t         req;
  logic [LW-1:0]     req_len;

  logic              res_valid;
  logic              res_take;
  stdi_status_t      res_status;
  logic [AW-1:0]     res_offset;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [OFF_W-1:0]  out_offset_r;

  // bytes are taken only while the engine is idle
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  stdi_collect #(
    .MAX_LEN (MAX_LEN)
  ) u_collect (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .char_code    (in_char_code),
    .last_char    (in_last_char),
    .share_suffix (in_share_suffix),
    .buf_we       (buf_we),
    .buf_waddr    (buf_waddr),
    .buf_wdata    (buf_wdata),
    .req          (req),
    .req_len      (req_len)
  );

  // the buffer is written only while collecting and read only by the
  // engine, so accesses never overlap
  stdi_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // packed zero-terminated entries
  stdi_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TABLE_BYTES)
  ) u_table_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  stdi_engine #(
    .TABLE_BYTES (TABLE_BYTES),
    .MAX_LEN     (MAX_LEN)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_len    (req_len),
    .busy       (busy),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_status (res_status),
    .res_offset (res_offset)
  );

  // load when the register is empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (res_take) begin
        out_status_r <= res_status;
        // offsets are reported modulo the result width
        out_offset_r <= OFF_W'(res_offset);
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_offset = out_offset_r;

endmodule

// ===== design/stdi_checker.sv =====
module stdi_checker import stdi_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last_char,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [OFF_W-1:0]  out_offset
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_offset))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the final byte starts the engine, which blocks the input
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_char |=> in_stall)
    else $error("input open after final byte");

  // other bytes never block the input
  a_byte_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_char |=> !in_stall)
    else $error("input blocked after plain byte");

  // rejected strings carry a zero offset
  a_reject_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_NOROOM) |-> out_offset == '0)
    else $error("nonzero offset on rejected string");

endmodule

bind string_table_dedup_insert stdi_checker u_stdi_checker (.*);
